>>> rtl/tcle_pkg.sv
// ----------------------------------------------------------------------------
// tcle_pkg: shared constants and types for the text console line editor
// Screen geometry, character codes, item kinds, register indexes and the
// result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tcle_pkg;

    localparam int SCREEN_COLUMNS    = 80;
    localparam int SCREEN_ROWS       = 25;
    localparam int LINE_BUFFER_DEPTH = 256;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COUNT_W = 8;
    localparam int CAP_W   = 9;
    localparam int KIND_W  = 2;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(LINE_BUFFER_DEPTH);
    localparam logic [CAP_W-1:0] CAP_MIN  = CAP_W'(1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_ECHO_ENABLE   = 1'b0;
    localparam logic REG_LINE_CAPACITY = 1'b1;

    typedef struct packed {
        logic                clear_request;
        logic                line_done;
        logic                buf_write;
        logic                cell_write;
        logic [CHAR_W-1:0]   buf_byte;
        logic [COUNT_W-1:0]  buf_index;
        logic [ROW_W-1:0]    pos_y;
        logic [COL_W-1:0]    pos_x;
        logic [ATTR_W-1:0]   cell_colour;
        logic [CHAR_W-1:0]   cell_char;
        logic [ROW_W-1:0]    cell_y;
        logic [COL_W-1:0]    cell_x;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/text_console_line_editor.sv
// ----------------------------------------------------------------------------
// text_console_line_editor: cursor engine and bounded line editor
// The result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one beat per cycle while the skid entry is empty; output register plus skid entry.
// Reset (sync, aresetn low): cursor home, line empty, echo on, capacity 256.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_line_editor (
    input  wire         aclk,
    input  wire         aresetn,
    // config write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [8:0]  cfg_data,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // char_code[7:0], colour[15:8]
    input  wire  [1:0]  s_tuser,   // kind[1:0]
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // cell_x[6:0], cell_y[11:7], cell_char[19:12],
                                   // cell_colour[27:20], pos_x[34:28],
                                   // pos_y[39:35], buf_index[47:40],
                                   // buf_byte[55:48]
    output logic [3:0]  m_tuser    // cell_write[0], buf_write[1], line_done[2],
                                   // clear_request[3]
);
    import tcle_pkg::*;

    logic                echo_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    result_t             out_reg, skid_reg, res;
    logic                out_valid_reg, skid_valid_reg;

    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   colour;
    logic                accept;

    logic [CAP_W-1:0]    cap_eff;
    logic [CAP_W-1:0]    limit;
    logic [ROW_W-1:0]    row_step;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_W-1:0]    adv_row;

    assign kind   = s_tuser;
    assign ch     = s_tdata[7:0];
    assign colour = s_tdata[15:8];

    assign cfg_ready = 1'b1;
    assign s_tready  = ~skid_valid_reg;
    assign accept    = s_tvalid & s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[55:0];
    assign m_tuser  = {out_reg.clear_request, out_reg.line_done,
                       out_reg.buf_write, out_reg.cell_write};

    // capacity 0 acts as 1, anything above the buffer depth clamps
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CAP_MIN;
        end else if (cap_reg > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
    end
    assign limit = cap_eff - CAP_MIN;

    // cursor moves shared by output, echo and newline
    assign row_step = (row_reg == LAST_ROW) ? row_reg : row_reg + 1'b1;
    assign adv_col  = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
    assign adv_row  = (col_reg == LAST_COL) ? row_step : row_reg;

    always_comb begin
        res        = '0;
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;

        case (kind)
            KIND_PUT: begin
                if (ch == CHAR_NL) begin
                    col_next = '0;
                    row_next = row_step;
                end else begin
                    res.cell_write  = 1'b1;
                    res.cell_x      = col_reg;
                    res.cell_y      = row_reg;
                    res.cell_char   = ch;
                    res.cell_colour = colour;
                    col_next        = adv_col;
                    row_next        = adv_row;
                end
            end
            KIND_CLEAR: begin
                res.cell_colour   = colour;
                res.clear_request = 1'b1;
                col_next          = '0;
                row_next          = '0;
            end
            KIND_KEY: begin
                if (ch == CHAR_NUL) begin
                    // no key
                end else if (ch == CHAR_NL) begin
                    res.buf_write = 1'b1;
                    res.buf_index = count_reg;
                    res.line_done = 1'b1;
                    count_next    = '0;
                    if (echo_reg) begin
                        col_next = '0;
                        row_next = row_step;
                    end
                end else if (ch == CHAR_BS) begin
                    if (count_reg != '0) begin
                        count_next    = count_reg - 1'b1;
                        res.buf_write = 1'b1;
                        res.buf_index = count_reg - 1'b1;
                        // erase stays put at the home cell
                        if (echo_reg && !(col_reg == '0 && row_reg == '0)) begin
                            if (col_reg == '0) begin
                                col_next = LAST_COL;
                                row_next = row_reg - 1'b1;
                            end else begin
                                col_next = col_reg - 1'b1;
                            end
                            res.cell_write  = 1'b1;
                            res.cell_x      = col_next;
                            res.cell_y      = row_next;
                            res.cell_char   = CHAR_SPACE;
                            res.cell_colour = colour;
                        end
                    end
                end else if ({1'b0, count_reg} < limit) begin
                    res.buf_write = 1'b1;
                    res.buf_index = count_reg;
                    res.buf_byte  = ch;
                    count_next    = count_reg + 1'b1;
                    if (echo_reg) begin
                        res.cell_write  = 1'b1;
                        res.cell_x      = col_reg;
                        res.cell_y      = row_reg;
                        res.cell_char   = ch;
                        res.cell_colour = colour;
                        col_next        = adv_col;
                        row_next        = adv_row;
                    end
                end
            end
            default: begin
                // unused kind: no effect
            end
        endcase

        res.pos_x = col_next;
        res.pos_y = row_next;
    end

    // config and editor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg  <= 1'b1;
            cap_reg   <= CAP_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ECHO_ENABLE:   echo_reg <= cfg_data[0];
                    REG_LINE_CAPACITY: cap_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                count_reg <= count_next;
            end
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.pos_x <= LAST_COL && out_reg.pos_y <= LAST_ROW))
        else $error("cursor outside the screen");

    a_done_writes_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.line_done) |->
            (out_reg.buf_write && out_reg.buf_byte == CHAR_NUL))
        else $error("line end without terminator write");

    a_clear_homes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && kind == KIND_CLEAR) |=> (col_reg == '0 && row_reg == '0))
        else $error("clear did not home the cursor");
`endif

endmodule

`default_nettype wire

>>> bench/tb_text_console_line_editor.sv
// ----------------------------------------------------------------------------
// tb_text_console_line_editor: self-checking bench for the console engine
// A driver takes queued console operations one beat at a time while the
// block's cursor, line buffer and echo behavior are predicted alongside.
// Every result beat is checked field by field against the prediction.
// Both stream sides stall at random. Echo and capacity are changed between
// phases once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_line_editor;
    timeunit 1ns;
    timeprecision 1ps;

    import tcle_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT = 27;
    localparam int unsigned STALL_LIMIT = 3000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] code;
        logic [ATTR_W-1:0] colour;
    } console_op_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_ECHO_ENABLE;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;

    text_console_line_editor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predicted console state and register copies
    int unsigned cur_col, cur_row, line_len;
    logic        echo_on = 1'b1;
    logic [CAP_W-1:0] capacity = CAP_RESET;

    console_op_t op_queue[$];
    result_t     screen_updates[$];
    console_op_t offered;
    int unsigned ops_queued, ops_sent, results_seen, mismatches;
    int unsigned lines_ended, keys_dropped, row_clamps;

    function automatic void put_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] colour,
                                     inout result_t r);
        if (ch == CHAR_NL) begin
            cur_col = 0;
            cur_row++;
        end else begin
            r.cell_write  = 1'b1;
            r.cell_x      = COL_W'(cur_col);
            r.cell_y      = ROW_W'(cur_row);
            r.cell_char   = ch;
            r.cell_colour = colour;
            cur_col++;
        end
        if (cur_col > SCREEN_COLUMNS - 1) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row > SCREEN_ROWS - 1) begin
            cur_row = SCREEN_ROWS - 1;
            row_clamps++;
        end
    endfunction

    function automatic result_t console_next(console_op_t op);
        result_t     r;
        int unsigned cap;
        r = '0;
        cap = (capacity == 0) ? 1 : (capacity > LINE_BUFFER_DEPTH) ? LINE_BUFFER_DEPTH
                                                                    : capacity;
        case (op.kind)
            KIND_PUT: put_char(op.code, op.colour, r);
            KIND_CLEAR: begin
                r.cell_colour   = op.colour;
                r.clear_request = 1'b1;
                cur_col = 0;
                cur_row = 0;
            end
            KIND_KEY: begin
                if (op.code == CHAR_NUL) begin
                    // no key: nothing happens
                end else if (op.code == CHAR_NL) begin
                    r.buf_write = 1'b1;
                    r.buf_index = COUNT_W'(line_len);
                    r.line_done = 1'b1;
                    line_len = 0;
                    lines_ended++;
                    if (echo_on)
                        put_char(CHAR_NL, op.colour, r);
                end else if (op.code == CHAR_BS) begin
                    if (line_len > 0) begin
                        line_len--;
                        r.buf_write = 1'b1;
                        r.buf_index = COUNT_W'(line_len);
                        // erase one cell back; stuck at home position
                        if (echo_on && !(cur_col == 0 && cur_row == 0)) begin
                            if (cur_col == 0) begin
                                cur_col = SCREEN_COLUMNS - 1;
                                cur_row--;
                            end else begin
                                cur_col--;
                            end
                            r.cell_write  = 1'b1;
                            r.cell_x      = COL_W'(cur_col);
                            r.cell_y      = ROW_W'(cur_row);
                            r.cell_char   = CHAR_SPACE;
                            r.cell_colour = op.colour;
                        end
                    end
                end else if (line_len < cap - 1) begin
                    r.buf_write = 1'b1;
                    r.buf_index = COUNT_W'(line_len);
                    r.buf_byte  = op.code;
                    line_len = (line_len + 1) & 8'hFF;
                    if (echo_on)
                        put_char(op.code, op.colour, r);
                end else begin
                    keys_dropped++;
                end
            end
            default: ;
        endcase
        r.pos_x = COL_W'(cur_col);
        r.pos_y = ROW_W'(cur_row);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatches < 10)
                $display("[%0t] result %0d: %s expected %0d, got %0d",
                         $realtime, results_seen, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_op(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] code,
                                     logic [ATTR_W-1:0] colour);
        console_op_t op;
        op.kind   = kind;
        op.code   = code;
        op.colour = colour;
        op_queue.push_back(op);
        ops_queued++;
    endfunction

    // Driver: offer queued operations, predict on each accepted beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                screen_updates.push_back(console_next(offered));
                ops_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0 &&
                    ((ops_sent >= 500 && ops_sent < 800) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    offered  = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.colour, offered.code};
                    s_tuser  <= offered.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result beat with the oldest prediction.
    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'({m_tuser, m_tdata});
                if (screen_updates.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] result beat with nothing expected: %h",
                                 $realtime, got);
                    mismatches++;
                end else begin
                    want = screen_updates.pop_front();
                    check_field("cell_write", want.cell_write, got.cell_write);
                    check_field("cell_x", want.cell_x, got.cell_x);
                    check_field("cell_y", want.cell_y, got.cell_y);
                    check_field("cell_char", want.cell_char, got.cell_char);
                    check_field("cell_colour", want.cell_colour, got.cell_colour);
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("buf_write", want.buf_write, got.buf_write);
                    check_field("buf_index", want.buf_index, got.buf_index);
                    check_field("buf_byte", want.buf_byte, got.buf_byte);
                    check_field("line_done", want.line_done, got.line_done);
                    check_field("clear_request", want.clear_request, got.clear_request);
                    results_seen++;
                end
            end
            m_tready <= (results_seen >= 500 && results_seen < 800) ||
                        $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin
        int unsigned quiet;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet == STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, logic [8:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ECHO_ENABLE)
            echo_on = value[0];
        else
            capacity = value;
    endtask

    task automatic wait_drained();
        while (results_seen != ops_queued)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] typed_char();
        return ($urandom_range(0, 15) == 0) ? CHAR_W'($urandom_range(0, 255))
                                            : CHAR_W'($urandom_range(32, 126));
    endfunction

    // Mostly typed lines and output runs, with clears and junk mixed in.
    task automatic add_random_ops(int unsigned count);
        int unsigned first, len, r, bs_odds;
        first = ops_queued;
        while (ops_queued - first < count) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 19) == 0) begin
                    len = $urandom_range(200, 300);
                    bs_odds = 40;
                end else begin
                    len = $urandom_range(0, 12);
                    bs_odds = 8;
                end
                repeat (len) begin
                    if ($urandom_range(1, bs_odds) == 1)
                        queue_op(KIND_KEY, CHAR_BS, ATTR_W'($urandom_range(0, 255)));
                    else
                        queue_op(KIND_KEY, typed_char(), ATTR_W'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 9) != 0)
                    queue_op(KIND_KEY, CHAR_NL, ATTR_W'($urandom_range(0, 255)));
            end else if (r < 75) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 170)
                                                  : $urandom_range(1, 15);
                repeat (len)
                    queue_op(KIND_PUT, CHAR_W'($urandom_range(0, 255)),
                             ATTR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) < 7)
                    queue_op(KIND_PUT, CHAR_NL, ATTR_W'($urandom_range(0, 255)));
            end else if (r < 85) begin
                repeat ($urandom_range(1, 6))
                    queue_op(KIND_PUT, CHAR_NL, ATTR_W'($urandom_range(0, 255)));
            end else if (r < 89) begin
                queue_op(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                         ATTR_W'($urandom_range(0, 255)));
            end else if (r < 94) begin
                queue_op(KIND_UNUSED, CHAR_W'($urandom_range(0, 255)),
                         ATTR_W'($urandom_range(0, 255)));
            end else begin
                queue_op(KIND_KEY, CHAR_W'($urandom_range(0, 255)),
                         ATTR_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic             echo_plan[9];
        logic [CAP_W-1:0] cap_plan[9];
        echo_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        cap_plan  = '{9'd1, 9'd0, 9'd2, 9'd256, 9'd511, 9'd300, 9'd5, 9'd17, 9'd256};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: echo on, capacity 256 from reset
        queue_op(KIND_KEY, CHAR_NUL, 8'hFF);     // no key
        queue_op(KIND_KEY, CHAR_BS, 8'h00);      // erase on empty line
        queue_op(KIND_KEY, 8'h41, 8'h00);
        queue_op(KIND_KEY, 8'hFF, 8'hFF);
        queue_op(KIND_KEY, CHAR_BS, 8'h3C);
        queue_op(KIND_KEY, CHAR_NL, 8'h11);      // line ends, cursor to row 1
        queue_op(KIND_KEY, 8'h61, 8'h22);
        queue_op(KIND_PUT, CHAR_NL, 8'h33);
        queue_op(KIND_KEY, CHAR_BS, 8'h44);      // erase wraps to end of row 1
        queue_op(KIND_KEY, 8'h62, 8'h55);
        queue_op(KIND_CLEAR, 8'h00, 8'hA5);      // line count survives the clear
        queue_op(KIND_KEY, CHAR_BS, 8'h66);      // erase at home: buffer only
        queue_op(KIND_PUT, CHAR_NUL, 8'h77);
        queue_op(KIND_PUT, CHAR_BS, 8'h88);
        queue_op(KIND_PUT, 8'hFF, 8'h5A);
        queue_op(KIND_UNUSED, 8'h41, 8'h99);
        queue_op(KIND_UNUSED, 8'hFF, 8'hFF);
        queue_op(KIND_KEY, CHAR_NL, 8'hC3);
        queue_op(KIND_CLEAR, 8'hFF, 8'h00);
        wait_drained();

        foreach (echo_plan[i]) begin
            write_reg(REG_ECHO_ENABLE, {8'($urandom_range(0, 255)), echo_plan[i]});
            write_reg(REG_LINE_CAPACITY, cap_plan[i]);
            add_random_ops(140);
            wait_drained();
        end

        $display("%0d operations checked over %0d echo/capacity settings", results_seen,
                 $size(echo_plan) + 1);
        $display("%0d lines ended, %0d keys dropped on full lines, %0d row clamps",
                 lines_ended, keys_dropped, row_clamps);
        if (mismatches == 0 && screen_updates.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
